// ===== rtl/dlps_pkg.sv =====
// ----------------------------------------------------------------------------
// dlps_pkg
// Shared types, step codes and the gain table function of the stereo
// delay-line pitch shifter.
// ----------------------------------------------------------------------------
package dlps_pkg;

  // Default sizes of the delay lines and the raised-cosine gain table.
  localparam int DELAY_DEPTH_DEF = 8192;
  localparam int COS_DEPTH_DEF   = 1024;

  // Fixed-point constants: pi and one in Q30.
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  // Configuration register indexes.
  localparam logic CFG_RATE  = 1'b0;
  localparam logic CFG_RATIO = 1'b1;

  // Lane step codes.
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_LDA  = 3'd1;
  localparam logic [2:0] OP_TAP1 = 3'd2;
  localparam logic [2:0] OP_TAP2 = 3'd3;
  localparam logic [2:0] OP_MUL1 = 3'd4;
  localparam logic [2:0] OP_MUL2 = 3'd5;
  localparam logic [2:0] OP_FIN  = 3'd6;

  // Control from the sequencer to each channel lane.
  typedef struct packed {
    logic       wr_en;
    logic       rd_ok;
    logic [2:0] op;
  } lane_ctrl_t;

  // Gain table entry: sin(x)^2 in Q15, with x in Q30 and the sine taken by
  // a nested Taylor series. Evaluated at elaboration only.
  function automatic logic [15:0] gain_fn(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] ss;
    begin
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
      s  = {32'd0, 32'((x * t) >> 30)};
      ss = (s * s) >> 45;
      return ss[15:0];
    end
  endfunction

endpackage

// ===== rtl/dlps_div.sv =====
// ----------------------------------------------------------------------------
// dlps_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dlps_div #(
  parameter int DVD_W = 34,
  parameter int DVS_W = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CW = $clog2(DVD_W);

  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [DVD_W-1:0] q_r, q_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W:0]   shifted;
  logic             fits;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    shifted = {rem_r, q_r[DVD_W-1]};
    fits    = shifted >= {1'b0, dvs_r};
  end

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      q_nxt   = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
    end else if (run_r) begin
      q_nxt   = {q_r[DVD_W-2:0], fits};
      rem_nxt = fits ? DVS_W'(shifted - {1'b0, dvs_r}) : shifted[DVS_W-1:0];
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(DVD_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== rtl/dlps_cfg.sv =====
// ----------------------------------------------------------------------------
// dlps_cfg
// Configuration registers. Derives the grain window from the sample rate
// by a reciprocal multiplication, and the per-sample phase step from the
// ratio and the window by a serial division.
// ----------------------------------------------------------------------------
module dlps_cfg #(
  parameter int DELAY_DEPTH = 8192,
  parameter int WIN_W       = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [17:0]      cfg_wdata,
  output logic [WIN_W-1:0] window,
  output logic [23:0]      delta,
  output logic             busy
);
  import dlps_pkg::*;

  localparam int MAX_WIN = DELAY_DEPTH * 1152 / 10;
  localparam int DVD_W   = 34;
  localparam int NUM_W   = 29;

  // rate * 11776 / 1000 equals rate * 1472 / 125; the division by 125 is a
  // multiplication by ceil(2^36 / 125) and a shift by 36, exact for any
  // numerator below 2^29.
  localparam logic [29:0] RECIP_125 = 30'd549755814;

  localparam logic [2:0] CS_IDLE = 3'd0;
  localparam logic [2:0] CS_WSET = 3'd1;
  localparam logic [2:0] CS_WDIV = 3'd2;
  localparam logic [2:0] CS_DSET = 3'd3;
  localparam logic [2:0] CS_DDIV = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [17:0]      rate_r;
  logic [15:0]      ratio_r;
  logic [WIN_W-1:0] window_r, window_nxt;
  logic [23:0]      delta_r, delta_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic             div_start;
  logic [DVD_W-1:0] div_dvd;
  logic [WIN_W-1:0] div_dvs;
  logic             div_done;
  logic [DVD_W-1:0] div_q;
  logic             ratio_neg;
  logic [15:0]      ratio_mag;
  logic [NUM_W-1:0] rate_num;
  logic [NUM_W+29:0] wprod;
  logic [22:0]      wq;

  dlps_div #(
    .DVD_W (DVD_W),
    .DVS_W (WIN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // Register writes land at once; derived values are then rebuilt.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= 18'd48000;
      ratio_r <= 16'd16384;
    end else if (cfg_we) begin
      if (cfg_index == CFG_RATE) begin
        rate_r <= cfg_wdata;
      end else begin
        ratio_r <= cfg_wdata[15:0];
      end
    end
  end

  // Operands of the window product and the step division.
  always_comb begin
    ratio_neg = ratio_r > 16'd16384;
    ratio_mag = ratio_neg ? (ratio_r - 16'd16384) : (16'd16384 - ratio_r);
    rate_num  = NUM_W'(rate_r) * NUM_W'(1472);
    wprod     = (NUM_W+30)'(num_r) * (NUM_W+30)'(RECIP_125);
    wq        = wprod[NUM_W+29:36];
  end

  // Sequencer: window = rate * 11776 / 1000, clamped, then step = |ratio - 16384| * 2^18 / window.
  always_comb begin
    state_nxt  = state_r;
    window_nxt = window_r;
    delta_nxt  = delta_r;
    num_nxt    = num_r;
    div_start  = 1'b0;
    div_dvd    = {ratio_mag, 18'd0};
    div_dvs    = window_r;
    case (state_r)
      CS_IDLE: begin
      end
      CS_WSET: begin
        num_nxt   = rate_num;
        state_nxt = CS_WDIV;
      end
      CS_WDIV: begin
        if (wq > 23'(MAX_WIN)) begin
          window_nxt = WIN_W'(MAX_WIN);
        end else if (wq < 23'(256)) begin
          window_nxt = WIN_W'(256);
        end else begin
          window_nxt = WIN_W'(wq);
        end
        state_nxt = CS_DSET;
      end
      CS_DSET: begin
        div_start = 1'b1;
        state_nxt = CS_DDIV;
      end
      CS_DDIV: begin
        if (div_done) begin
          delta_nxt = ratio_neg ? (24'd0 - div_q[23:0]) : div_q[23:0];
          state_nxt = CS_IDLE;
        end
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
    if (cfg_we) begin
      state_nxt = CS_WSET;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_WSET;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    window_r <= window_nxt;
    delta_r  <= delta_nxt;
    num_r    <= num_nxt;
  end

  assign window = window_r;
  assign delta  = delta_r;
  assign busy   = state_r != CS_IDLE;

  // A settled window always lies between one sample and the clamp.
  a_win_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == CS_IDLE) |-> (window_r >= WIN_W'(256) && window_r <= WIN_W'(MAX_WIN)))
    else $error("window out of range while idle");

  // Every register write restarts the derivation.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (state_r == CS_WSET))
    else $error("config write did not restart derivation");

endmodule

// ===== rtl/dlps_lane.sv =====
// ----------------------------------------------------------------------------
// dlps_lane
// One channel: its delay line, two interpolated taps and the crossfade.
// ----------------------------------------------------------------------------
module dlps_lane #(
  parameter int DELAY_DEPTH = 8192,
  parameter int AW          = 13
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dlps_pkg::lane_ctrl_t ctrl,
  input  logic [AW-1:0]       waddr,
  input  logic signed [15:0]  wdata,
  input  logic [AW-1:0]       raddr,
  input  logic [7:0]          frac,
  input  logic [15:0]         gain1,
  input  logic [15:0]         gain2,
  output logic signed [15:0]  res
);
  import dlps_pkg::*;

  localparam logic signed [43:0] ROUND = 44'sd4194304;

  logic signed [15:0] mem [DELAY_DEPTH];
  logic signed [15:0] q_r;
  logic               ok_r;
  logic [2:0]         op_r;
  logic signed [15:0] rdv;
  logic signed [15:0] a_r;
  logic signed [16:0] diff;
  logic signed [8:0]  frac_s;
  logic signed [25:0] fdiff;
  logic signed [25:0] tap_calc;
  logic signed [25:0] tap1_r;
  logic signed [25:0] tap2_r;
  logic signed [25:0] mul_t;
  logic signed [16:0] mul_g;
  logic signed [42:0] mprod;
  logic signed [42:0] p_r;
  logic signed [43:0] acc_r;
  logic signed [20:0] qv;
  logic signed [15:0] res_r;

  // Delay line memory, registered read.
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[waddr] <= wdata;
    end
    q_r <= mem[raddr];
  end

  // Entries never written read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r <= 1'b0;
      op_r <= OP_NONE;
    end else begin
      ok_r <= ctrl.rd_ok;
      op_r <= ctrl.op;
    end
  end

  // Linear interpolation a*256 + f*(b - a), b being the word just read.
  always_comb begin
    rdv      = ok_r ? q_r : 16'sd0;
    diff     = 17'(rdv) - 17'(a_r);
    frac_s   = $signed({1'b0, frac});
    fdiff    = 26'(frac_s) * 26'(diff);
    tap_calc = $signed({{2{a_r[15]}}, a_r, 8'd0}) + fdiff;
  end

  // One multiplier serves both crossfade products.
  always_comb begin
    mul_t = (ctrl.op == OP_MUL1) ? tap1_r : tap2_r;
    mul_g = (ctrl.op == OP_MUL1) ? $signed({1'b0, gain1}) : $signed({1'b0, gain2});
    mprod = 43'(mul_t) * 43'(mul_g);
    qv    = 21'(acc_r >>> 23);
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LDA:  a_r    <= rdv;
      OP_TAP1: tap1_r <= tap_calc;
      OP_TAP2: tap2_r <= tap_calc;
      OP_MUL1: p_r    <= mprod;
      OP_MUL2: acc_r  <= 44'(p_r) + 44'(mprod) + ROUND;
      OP_FIN: begin
        if (qv > 21'sd32767) begin
          res_r <= 16'sh7FFF;
        end else if (qv < -21'sd32768) begin
          res_r <= 16'sh8000;
        end else begin
          res_r <= qv[15:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign res = res_r;

  // The read-data step codes come in the cycle after their read; op_r keeps the pairing visible.
  a_tap_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_TAP1 || ctrl.op == OP_TAP2) |-> (op_r == OP_NONE || op_r == OP_LDA))
    else $error("tap step without preceding load");

endmodule

// ===== rtl/delay_line_pitch_shifter.sv =====
// ----------------------------------------------------------------------------
// delay_line_pitch_shifter
// Each request walks the steps DLY1, DLY2, RA1, RB1, RA2, RB2, TAP2, MUL1,
// MUL2 and FIN, and no new request is taken before it is done; the steps
// are set by the single read port of each delay line (four reads) and the
// shared crossfade multiplier. Reset and every config write rebuild window
// and phase step, the step through a serial divider; requests are stalled
// meanwhile. Delay lines read as zero until written, tracked by a fill mark.
// ----------------------------------------------------------------------------
module delay_line_pitch_shifter #(
  parameter int DELAY_DEPTH = dlps_pkg::DELAY_DEPTH_DEF,
  parameter int COS_DEPTH   = dlps_pkg::COS_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_left_sample,
  input  logic signed [15:0] in_right_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_left_out,
  output logic signed [15:0] out_right_out,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [17:0]        cfg_wdata
);
  import dlps_pkg::*;

  localparam int AW      = $clog2(DELAY_DEPTH);
  localparam int POSW    = AW + 8;
  localparam int MAX_WIN = DELAY_DEPTH * 1152 / 10;
  localparam int WIN_W   = $clog2(MAX_WIN + 1);
  localparam int CW      = $clog2(COS_DEPTH);
  localparam logic [POSW:0] LINE_Q8 = (POSW+1)'(DELAY_DEPTH * 256);

  // Sequencer steps.
  localparam logic [3:0] CNT_IDLE = 4'd0;
  localparam logic [3:0] CNT_DLY1 = 4'd1;
  localparam logic [3:0] CNT_DLY2 = 4'd2;
  localparam logic [3:0] CNT_RA1  = 4'd3;
  localparam logic [3:0] CNT_RB1  = 4'd4;
  localparam logic [3:0] CNT_RA2  = 4'd5;
  localparam logic [3:0] CNT_RB2  = 4'd6;
  localparam logic [3:0] CNT_TAP2 = 4'd7;
  localparam logic [3:0] CNT_MUL1 = 4'd8;
  localparam logic [3:0] CNT_MUL2 = 4'd9;
  localparam logic [3:0] CNT_FIN  = 4'd10;

  logic [3:0]         cnt_r, cnt_nxt;
  logic [23:0]        phase_r;
  logic [AW-1:0]      wp_r;
  logic               wrapped_r;
  logic               out_valid_r, out_valid_nxt;
  logic [WIN_W:0]     dly1_r, dly2_r;
  logic [POSW-1:0]    pos1_r, pos2_r;
  logic [15:0]        g1_r;
  logic [15:0]        g2;
  logic [15:0]        gain_tbl [COS_DEPTH];
  logic [WIN_W-1:0]   window;
  logic [23:0]        delta;
  logic               cfg_busy;
  logic               in_go;
  logic               fin_go;
  logic [23:0]        mop;
  logic [24+WIN_W-1:0] dprod;
  logic [WIN_W:0]     dly_calc;
  logic [WIN_W:0]     dly_sel;
  logic [POSW:0]      pdiff;
  logic [POSW-1:0]    pos_calc;
  logic [24+CW-1:0]   gprod;
  logic [AW-1:0]      ridx;
  logic [AW-1:0]      raddr;
  logic [7:0]         frac;
  logic               rd_ok;
  lane_ctrl_t         ctrl;
  logic signed [15:0] left_res;
  logic signed [15:0] right_res;

  // Raised-cosine gain table, fixed at elaboration.
  for (genvar k = 0; k < COS_DEPTH; k++) begin : g_tbl
    localparam logic [63:0] KF = (2 * k > COS_DEPTH) ? 64'(COS_DEPTH - k) : 64'(k);
    localparam logic [63:0] XV = (PI_Q30 * KF) / COS_DEPTH;
    assign gain_tbl[k] = gain_fn(XV);
  end

  dlps_cfg #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .WIN_W       (WIN_W)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .window    (window),
    .delta     (delta),
    .busy      (cfg_busy)
  );

  // Handshake.
  always_comb begin
    in_stall = (cnt_r != CNT_IDLE) || cfg_busy;
    in_go    = in_valid && !in_stall;
    fin_go   = (cnt_r == CNT_FIN) && !(out_valid_r && out_stall);
  end

  // Tap delay = (phase * window) >> 24 + one sample; second tap half a grain on.
  always_comb begin
    mop      = (cnt_r == CNT_DLY1) ? phase_r : (phase_r + 24'h800000);
    dprod    = (24+WIN_W)'(mop) * (24+WIN_W)'(window);
    dly_calc = {1'b0, dprod[24 +: WIN_W]} + (WIN_W+1)'(256);
    gprod    = (24+CW)'(phase_r) * (24+CW)'(COS_DEPTH);
    g2       = 16'(17'd32768 - 17'(g1_r));
  end

  // Read position behind the write pointer, wrapped around the line.
  always_comb begin
    dly_sel  = (cnt_r == CNT_DLY2) ? dly1_r : dly2_r;
    pdiff    = {1'b0, wp_r, 8'd0} - (POSW+1)'(dly_sel);
    pos_calc = pdiff[POSW] ? POSW'(pdiff + LINE_Q8) : pdiff[POSW-1:0];
  end

  // Read addresses: first and next entry of each tap.
  always_comb begin
    ridx  = (cnt_r == CNT_RA1 || cnt_r == CNT_RB1) ? pos1_r[POSW-1:8] : pos2_r[POSW-1:8];
    raddr = ridx;
    if (cnt_r == CNT_RB1 || cnt_r == CNT_RB2) begin
      raddr = (ridx == AW'(DELAY_DEPTH - 1)) ? '0 : (ridx + AW'(1));
    end
    rd_ok = wrapped_r || (raddr <= wp_r);
    frac  = (cnt_r == CNT_RA2) ? pos1_r[7:0] : pos2_r[7:0];
  end

  // Lane steps for each sequencer state.
  always_comb begin
    ctrl.wr_en = in_go;
    ctrl.rd_ok = rd_ok;
    ctrl.op    = OP_NONE;
    case (cnt_r)
      CNT_RB1:  ctrl.op = OP_LDA;
      CNT_RA2:  ctrl.op = OP_TAP1;
      CNT_RB2:  ctrl.op = OP_LDA;
      CNT_TAP2: ctrl.op = OP_TAP2;
      CNT_MUL1: ctrl.op = OP_MUL1;
      CNT_MUL2: ctrl.op = OP_MUL2;
      CNT_FIN:  ctrl.op = fin_go ? OP_FIN : OP_NONE;
      default:  ctrl.op = OP_NONE;
    endcase
  end

  dlps_lane #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .AW          (AW)
  ) u_lane_left (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .waddr (wp_r),
    .wdata (in_left_sample),
    .raddr (raddr),
    .frac  (frac),
    .gain1 (g1_r),
    .gain2 (g2),
    .res   (left_res)
  );

  dlps_lane #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .AW          (AW)
  ) u_lane_right (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .waddr (wp_r),
    .wdata (in_right_sample),
    .raddr (raddr),
    .frac  (frac),
    .gain1 (g1_r),
    .gain2 (g2),
    .res   (right_res)
  );

  // Sequencer and output valid.
  always_comb begin
    cnt_nxt = cnt_r;
    if (cnt_r == CNT_IDLE) begin
      if (in_go) begin
        cnt_nxt = CNT_DLY1;
      end
    end else if (cnt_r == CNT_FIN) begin
      if (fin_go) begin
        cnt_nxt = CNT_IDLE;
      end
    end else begin
      cnt_nxt = cnt_r + 4'd1;
    end
    out_valid_nxt = out_valid_r && out_stall;
    if (fin_go) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= CNT_IDLE;
      out_valid_r <= 1'b0;
      phase_r     <= '0;
      wp_r        <= '0;
      wrapped_r   <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_go) begin
        phase_r <= phase_r + delta;
      end
      if (fin_go) begin
        if (wp_r == AW'(DELAY_DEPTH - 1)) begin
          wp_r      <= '0;
          wrapped_r <= 1'b1;
        end else begin
          wp_r <= wp_r + AW'(1);
        end
      end
    end
  end

  // Per-request working registers.
  always_ff @(posedge clk) begin
    if (cnt_r == CNT_DLY1) begin
      dly1_r <= dly_calc;
      g1_r   <= gain_tbl[gprod[24 +: CW]];
    end
    if (cnt_r == CNT_DLY2) begin
      dly2_r <= dly_calc;
      pos1_r <= pos_calc;
    end
    if (cnt_r == CNT_RA1) begin
      pos2_r <= pos_calc;
    end
  end

  // Both lanes finish together; their results form one output request.
  assign out_valid     = out_valid_r;
  assign out_left_out  = left_res;
  assign out_right_out = right_res;

  // A finished request always shows up as a valid result.
  a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> out_valid_r)
    else $error("finished request not presented");

  // The write pointer moves only when a request completes.
  a_wp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fin_go |=> $stable(wp_r))
    else $error("write pointer moved outside completion");

endmodule
